@@ src/button_mode_led_blinker_macros.svh @@
// assertion macros for the button mode led blinker
`ifndef BUTTON_MODE_LED_BLINKER_MACROS_SVH
`define BUTTON_MODE_LED_BLINKER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BML_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BML_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BML_ASSERT_IMP(label, clk, rst, ante, cons)
`define BML_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/bml_pkg.sv @@
// shared types and constants for the button mode led blinker
`default_nettype none
package bml_pkg;

  localparam int SampleDividerDefault = 5;

  localparam logic [6:0] DutyMax = 7'd100;

  localparam logic [6:0] DutyLevel0Reset    = 7'd10;
  localparam logic [6:0] DutyLevel1Reset    = 7'd50;
  localparam logic [6:0] DutyLevel2Reset    = 7'd80;
  localparam logic [7:0] BlinkPeriod0Reset  = 8'd10;
  localparam logic [7:0] BlinkPeriod1Reset  = 8'd50;
  localparam logic [7:0] BlinkPeriod2Reset  = 8'd100;
  localparam logic [7:0] LongHoldTicksReset = 8'd100;
  localparam logic [3:0] ShortPressReset    = 4'd3;

  typedef enum logic [2:0] {
    REG_DUTY_LEVEL_0      = 3'd0,
    REG_DUTY_LEVEL_1      = 3'd1,
    REG_DUTY_LEVEL_2      = 3'd2,
    REG_BLINK_PERIOD_0    = 3'd3,
    REG_BLINK_PERIOD_1    = 3'd4,
    REG_BLINK_PERIOD_2    = 3'd5,
    REG_LONG_HOLD_TICKS   = 3'd6,
    REG_SHORT_PRESS_LIMIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] duty_level_0;
    logic [6:0] duty_level_1;
    logic [6:0] duty_level_2;
    logic [7:0] blink_period_0;
    logic [7:0] blink_period_1;
    logic [7:0] blink_period_2;
    logic [7:0] long_hold_ticks;
    logic [3:0] short_press_limit;
  } cfg_t;

  typedef struct packed {
    logic [6:0] duty;
    logic       led_next_on;
    logic [1:0] duty_mode;
    logic       duty_mode_changed;
    logic [1:0] blink_mode;
  } res_t;

  function automatic logic [1:0] next_mode(input logic [1:0] m);
    return (m >= 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

endpackage
`default_nettype wire

@@ src/button_mode_led_blinker.sv @@
// button mode led blinker top level: register port, input and result channels
//
// One input transfer is one tick carrying the button level; each tick gives
// exactly one result transfer with the LED duty, the next blink phase, the
// duty and blink modes, and a flag for a short press seen on that tick.
// The input channel (in_valid, in_stall, button) is taken whenever the result
// register is empty or is being emptied in the same cycle, so ticks flow at
// one per clock. A result appears on out_valid the cycle after its tick is
// taken; throughput one tick per cycle while no stall is held, set by the single
// result register behind the per-tick counter logic.
// When the receiver holds out_stall with a result waiting, the result holds
// still and in_stall rises until it is taken; no tick is lost or repeated.
// Synchronous reset clears the counters and modes, loads the register defaults
// and empties the result register. Registers sit at byte address 4*index on the
// APB port. The user must write them only while no tick is in flight; not enforced.
`default_nettype none
module button_mode_led_blinker #(
  parameter int SAMPLE_DIVIDER = bml_pkg::SampleDividerDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        button,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       duty,
  output logic             led_next_on,
  output logic [1:0]       duty_mode,
  output logic             duty_mode_changed,
  output logic [1:0]       blink_mode,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bml_pkg::cfg_t     cfg;
  bml_pkg::res_t     res;
  bml_pkg::res_t     res_q;
  bml_pkg::reg_idx_t reg_idx;
  logic              accept;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = bml_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_level_0      <= bml_pkg::DutyLevel0Reset;
      cfg.duty_level_1      <= bml_pkg::DutyLevel1Reset;
      cfg.duty_level_2      <= bml_pkg::DutyLevel2Reset;
      cfg.blink_period_0    <= bml_pkg::BlinkPeriod0Reset;
      cfg.blink_period_1    <= bml_pkg::BlinkPeriod1Reset;
      cfg.blink_period_2    <= bml_pkg::BlinkPeriod2Reset;
      cfg.long_hold_ticks   <= bml_pkg::LongHoldTicksReset;
      cfg.short_press_limit <= bml_pkg::ShortPressReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        bml_pkg::REG_DUTY_LEVEL_0:      cfg.duty_level_0      <= pwdata[6:0];
        bml_pkg::REG_DUTY_LEVEL_1:      cfg.duty_level_1      <= pwdata[6:0];
        bml_pkg::REG_DUTY_LEVEL_2:      cfg.duty_level_2      <= pwdata[6:0];
        bml_pkg::REG_BLINK_PERIOD_0:    cfg.blink_period_0    <= pwdata[7:0];
        bml_pkg::REG_BLINK_PERIOD_1:    cfg.blink_period_1    <= pwdata[7:0];
        bml_pkg::REG_BLINK_PERIOD_2:    cfg.blink_period_2    <= pwdata[7:0];
        bml_pkg::REG_LONG_HOLD_TICKS:   cfg.long_hold_ticks   <= pwdata[7:0];
        bml_pkg::REG_SHORT_PRESS_LIMIT: cfg.short_press_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bml_pkg::REG_DUTY_LEVEL_0:      prdata = {25'd0, cfg.duty_level_0};
      bml_pkg::REG_DUTY_LEVEL_1:      prdata = {25'd0, cfg.duty_level_1};
      bml_pkg::REG_DUTY_LEVEL_2:      prdata = {25'd0, cfg.duty_level_2};
      bml_pkg::REG_BLINK_PERIOD_0:    prdata = {24'd0, cfg.blink_period_0};
      bml_pkg::REG_BLINK_PERIOD_1:    prdata = {24'd0, cfg.blink_period_1};
      bml_pkg::REG_BLINK_PERIOD_2:    prdata = {24'd0, cfg.blink_period_2};
      bml_pkg::REG_LONG_HOLD_TICKS:   prdata = {24'd0, cfg.long_hold_ticks};
      bml_pkg::REG_SHORT_PRESS_LIMIT: prdata = {28'd0, cfg.short_press_limit};
      default:                        prdata = 32'd0;
    endcase
  end

  // result register empties or refills in the same cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  bml_core #(
    .SAMPLE_DIVIDER(SAMPLE_DIVIDER)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .button (button),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign duty              = res_q.duty;
  assign led_next_on       = res_q.led_next_on;
  assign duty_mode         = res_q.duty_mode;
  assign duty_mode_changed = res_q.duty_mode_changed;
  assign blink_mode        = res_q.blink_mode;

endmodule
`default_nettype wire

@@ src/bml_core.sv @@
// blink timer, long hold counter and short press sampler
`default_nettype none
`include "button_mode_led_blinker_macros.svh"
module bml_core #(
  parameter int SAMPLE_DIVIDER = bml_pkg::SampleDividerDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          button,
  input  wire bml_pkg::cfg_t cfg,
  output bml_pkg::res_t      res
);

  localparam int PhaseW = (SAMPLE_DIVIDER > 1) ? $clog2(SAMPLE_DIVIDER) : 1;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(SAMPLE_DIVIDER - 1);

  logic [7:0]        tick_count, tick_count_next;
  logic [7:0]        hold_count, hold_count_next;
  logic              blink_on_next, blink_on_next_next;
  logic [6:0]        duty_out, duty_out_next;
  logic [1:0]        duty_sel, duty_sel_next;
  logic [1:0]        blink_sel, blink_sel_next;
  logic [3:0]        press_samples, press_samples_next;
  logic [PhaseW-1:0] divider_phase, divider_phase_next;
  logic              changed;

  logic [7:0] tick_inc;
  logic [7:0] period;
  logic [6:0] level_raw;
  logic [6:0] level;
  logic       toggle;
  logic [7:0] hold_inc;
  logic [4:0] samples_inc;

  always_comb begin
    tick_inc = (tick_count == 8'd255) ? tick_count : tick_count + 8'd1;
    unique case (blink_sel)
      2'd0:    period = cfg.blink_period_0;
      2'd1:    period = cfg.blink_period_1;
      default: period = cfg.blink_period_2;
    endcase
    unique case (duty_sel)
      2'd0:    level_raw = cfg.duty_level_0;
      2'd1:    level_raw = cfg.duty_level_1;
      default: level_raw = cfg.duty_level_2;
    endcase
    level  = (level_raw > bml_pkg::DutyMax) ? bml_pkg::DutyMax : level_raw;
    toggle = tick_inc > period;

    tick_count_next    = toggle ? 8'd0 : tick_inc;
    duty_out_next      = toggle ? (blink_on_next ? level : 7'd0) : duty_out;
    blink_on_next_next = blink_on_next ^ toggle;

    // long hold
    hold_inc       = (hold_count == 8'd255) ? hold_count : hold_count + 8'd1;
    blink_sel_next = blink_sel;
    if (!button) begin
      hold_count_next = 8'd0;
    end else if (hold_inc >= cfg.long_hold_ticks) begin
      hold_count_next = 8'd0;
      blink_sel_next  = bml_pkg::next_mode(blink_sel);
    end else begin
      hold_count_next = hold_inc;
    end

    // divided sampler
    samples_inc        = {1'b0, press_samples} + 5'd1;
    press_samples_next = press_samples;
    duty_sel_next      = duty_sel;
    changed            = 1'b0;
    if (divider_phase == PhaseLast) begin
      divider_phase_next = '0;
      if (button) begin
        press_samples_next = (samples_inc > {1'b0, cfg.short_press_limit}) ?
                             cfg.short_press_limit : samples_inc[3:0];
      end else begin
        if (press_samples != 4'd0 && press_samples < cfg.short_press_limit) begin
          duty_sel_next = bml_pkg::next_mode(duty_sel);
          changed       = 1'b1;
        end
        press_samples_next = 4'd0;
      end
    end else begin
      divider_phase_next = divider_phase + PhaseW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 8'd0;
      hold_count    <= 8'd0;
      blink_on_next <= 1'b1;
      duty_out      <= 7'd0;
      duty_sel      <= 2'd0;
      blink_sel     <= 2'd0;
      press_samples <= 4'd0;
      divider_phase <= '0;
    end else if (accept) begin
      tick_count    <= tick_count_next;
      hold_count    <= hold_count_next;
      blink_on_next <= blink_on_next_next;
      duty_out      <= duty_out_next;
      duty_sel      <= duty_sel_next;
      blink_sel     <= blink_sel_next;
      press_samples <= press_samples_next;
      divider_phase <= divider_phase_next;
    end
  end

  assign res = '{duty:              duty_out_next,
                 led_next_on:       blink_on_next_next,
                 duty_mode:         duty_sel_next,
                 duty_mode_changed: changed,
                 blink_mode:        blink_sel_next};

  `BML_ASSERT_IMP(a_change_on_sample, clk, rst, accept && changed,
                  divider_phase == PhaseLast && !button)
  `BML_ASSERT_NEXT(a_release_clears_hold, clk, rst, accept && !button,
                   hold_count == 8'd0)
  `BML_ASSERT_NEXT(a_idle_holds_timer, clk, rst, !accept,
                   $stable(tick_count) && $stable(divider_phase))
  `BML_ASSERT_NEXT(a_duty_in_range, clk, rst, accept, duty_out <= bml_pkg::DutyMax)

endmodule
`default_nettype wire
